// ----- sv/fsc_pkg.sv -----
// fsc_pkg: shared types, constants and saturating helpers for the frustum sphere culler
// used by fsc_mul, fsc_div, the top level frustum_sphere_culler and the testbench
package fsc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PLANE_CNT     = 6;

  typedef enum logic [1:0] {
    ACT_LOAD_VIEW = 2'd0,
    ACT_LOAD_PROJ = 2'd1,
    ACT_BUILD     = 2'd2,
    ACT_TEST      = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLIP_MUL,
    S_CLIP_WAIT,
    S_CLIP_ACC,
    S_EXTRACT,
    S_LEN_MUL,
    S_LEN_WAIT,
    S_LEN_ACC,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_ZERO,
    S_DIV_GO,
    S_DIV_WAIT,
    S_TEST_MUL,
    S_TEST_WAIT,
    S_TEST_ACC,
    S_TEST_D
  } state_e;

  // strobes from the sequencer to the shared units
  typedef struct packed {
    logic mul_load;
    logic sqrt_start;
    logic div_start;
  } fsc_ctrl_t;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sadd32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] s;
    s = {{32{a[31]}}, a} + {{32{b[31]}}, b};
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] ssub32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] s;
    s = {{32{a[31]}}, a} - {{32{b[31]}}, b};
    return sat32(s);
  endfunction

endpackage

// ----- sv/frustum_sphere_culler.sv -----
// frustum_sphere_culler: matrix load, frustum plane build and sphere test sequencer
// instantiates fsc_mul, fsc_sqrt and fsc_div; uses fsc_pkg
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, action_i, ...     | transaction into the block
//   out     | out_valid_o, out_stall_i, inside_res_o    | one transaction per sphere test
//
// a load is written into its matrix as it is accepted; a sphere test runs, for each of the
// six planes, three passes through the shared multiplier (mul, wait, accumulate) plus one
// step for the offset, and its result then goes to the output register
// a build computes the clip matrix through the shared multiplier, extracts the planes,
// then per plane accumulates the squared length, takes the square root and runs four divides
// (four zero writes instead when the normal has zero length)
// reset clears matrices and planes at once; in_stall_o is high while an item is in work
// a finished test waits for the output register if it still holds an untaken result
module frustum_sphere_culler #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [3:0]         matrix_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        sphere_radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               inside_res_o
);
  import fsc_pkg::*;

  state_e state_q, state_d;
  fsc_ctrl_t ctrl;

  logic signed [31:0] view_q  [16];
  logic signed [31:0] proj_q  [16];
  logic signed [31:0] plane_q [24];
  logic signed [31:0] clip_w_q [4];
  logic signed [31:0] clip_c_q [4][3];

  logic [1:0] row_q, col_q, k_q, cmp_q;
  logic [2:0] pl_q;
  logic signed [31:0] acc_q, cx_q, cy_q, cz_q;
  logic [30:0] radius_q;
  logic [63:0] len2_q;
  logic [31:0] root_q;
  logic inside_q, out_valid_q, res_q;

  logic in_acc;
  logic signed [31:0] mul_a, mul_b, fixed, plane_rd, acc_new, ctr_sel, ext_w, ext_c;
  logic signed [31:0] d_new, ext_val, quo;
  logic signed [63:0] prod;
  logic [31:0] sq_root;
  logic sq_done, dv_done, ext_add, d_pass, out_busy, last_cmp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;
  assign plane_rd   = plane_q[{pl_q, cmp_q}];

  // shared arithmetic units
  fsc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .load_i (ctrl.mul_load),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .fixed_o(fixed)
  );

  fsc_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl.sqrt_start),
    .radicand_i(len2_q),
    .done_o    (sq_done),
    .root_o    (sq_root)
  );

  fsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl.div_start),
    .num_i  (plane_rd),
    .den_i  (root_q),
    .done_o (dv_done),
    .quo_o  (quo)
  );

  // multiplier operand select
  always_comb begin
    case (cmp_q)
      2'd0:    ctr_sel = cx_q;
      2'd1:    ctr_sel = cy_q;
      default: ctr_sel = cz_q;
    endcase
    case (state_q)
      S_CLIP_MUL: begin
        mul_a = view_q[{row_q, k_q}];
        mul_b = proj_q[{k_q, col_q}];
      end
      S_TEST_MUL: begin
        mul_a = plane_rd;
        mul_b = ctr_sel;
      end
      default: begin
        mul_a = plane_rd;
        mul_b = plane_rd;
      end
    endcase
  end

  // accumulate, extraction and distance arithmetic
  always_comb begin
    acc_new = (((state_q == S_CLIP_ACC) && (k_q == 2'd0)) ||
               ((state_q == S_TEST_ACC) && (cmp_q == 2'd0))) ? fixed : sadd32(acc_q, fixed);
    ext_w   = clip_w_q[cmp_q];
    ext_c   = clip_c_q[cmp_q][pl_q[2:1]];
    ext_add = (pl_q == 3'd1) || (pl_q == 3'd2) || (pl_q == 3'd5);
    ext_val = ext_add ? sadd32(ext_w, ext_c) : ssub32(ext_w, ext_c);
    d_new   = sadd32(acc_q, plane_rd);
    d_pass  = $signed({d_new[31], d_new}) > -$signed({2'b00, radius_q});
    last_cmp = (cmp_q == 2'd3);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (action_i == ACT_BUILD)) begin
          state_d = S_CLIP_MUL;
        end else if (in_acc && (action_i == ACT_TEST)) begin
          state_d = S_TEST_MUL;
        end
      end
      S_CLIP_MUL:  state_d = S_CLIP_WAIT;
      S_CLIP_WAIT: state_d = S_CLIP_ACC;
      S_CLIP_ACC: begin
        if ((k_q == 2'd3) && (row_q == 2'd3) && (col_q == 2'd3)) begin
          state_d = S_EXTRACT;
        end else begin
          state_d = S_CLIP_MUL;
        end
      end
      S_EXTRACT: begin
        if ((pl_q == 3'(PLANE_CNT - 1)) && last_cmp) begin
          state_d = S_LEN_MUL;
        end
      end
      S_LEN_MUL:  state_d = S_LEN_WAIT;
      S_LEN_WAIT: state_d = S_LEN_ACC;
      S_LEN_ACC:  state_d = (cmp_q == 2'd2) ? S_SQRT_GO : S_LEN_MUL;
      S_SQRT_GO:  state_d = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (sq_done) begin
          state_d = (sq_root == '0) ? S_ZERO : S_DIV_GO;
        end
      end
      S_ZERO: begin
        if (last_cmp) begin
          state_d = (pl_q == 3'(PLANE_CNT - 1)) ? S_IDLE : S_LEN_MUL;
        end
      end
      S_DIV_GO: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (dv_done) begin
          if (last_cmp) begin
            state_d = (pl_q == 3'(PLANE_CNT - 1)) ? S_IDLE : S_LEN_MUL;
          end else begin
            state_d = S_DIV_GO;
          end
        end
      end
      S_TEST_MUL:  state_d = S_TEST_WAIT;
      S_TEST_WAIT: state_d = S_TEST_ACC;
      S_TEST_ACC:  state_d = (cmp_q == 2'd2) ? S_TEST_D : S_TEST_MUL;
      S_TEST_D: begin
        if (pl_q != 3'(PLANE_CNT - 1)) begin
          state_d = S_TEST_MUL;
        end else if (!out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // unit strobes
  always_comb begin
    ctrl = '0;
    case (state_q)
      S_CLIP_MUL, S_LEN_MUL, S_TEST_MUL: ctrl.mul_load   = 1'b1;
      S_SQRT_GO:                         ctrl.sqrt_start = 1'b1;
      S_DIV_GO:                          ctrl.div_start  = 1'b1;
      default:                           ctrl = '0;
    endcase
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_TEST_D) && (pl_q == 3'(PLANE_CNT - 1)) && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // matrices and plane store, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 16; e++) begin
        view_q[e] <= '0;
        proj_q[e] <= '0;
      end
      for (int e = 0; e < 24; e++) begin
        plane_q[e] <= '0;
      end
    end else begin
      if (in_acc && (action_i == ACT_LOAD_VIEW)) begin
        view_q[matrix_index_i] <= element_value_i;
      end
      if (in_acc && (action_i == ACT_LOAD_PROJ)) begin
        proj_q[matrix_index_i] <= element_value_i;
      end
      case (state_q)
        S_EXTRACT: plane_q[{pl_q, cmp_q}] <= ext_val;
        S_ZERO:    plane_q[{pl_q, cmp_q}] <= '0;
        S_DIV_WAIT: begin
          if (dv_done) begin
            plane_q[{pl_q, cmp_q}] <= quo;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      k_q   <= '0;
      pl_q  <= '0;
      cmp_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          row_q <= '0;
          col_q <= '0;
          k_q   <= '0;
          pl_q  <= '0;
          cmp_q <= '0;
        end
        S_CLIP_ACC: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) begin
            col_q <= col_q + 2'd1;
            if (col_q == 2'd3) begin
              row_q <= row_q + 2'd1;
            end
          end
        end
        S_EXTRACT: begin
          cmp_q <= cmp_q + 2'd1;
          if (last_cmp) begin
            pl_q <= (pl_q == 3'(PLANE_CNT - 1)) ? 3'd0 : pl_q + 3'd1;
          end
        end
        S_LEN_ACC, S_TEST_ACC: cmp_q <= cmp_q + 2'd1;
        S_SQRT_WAIT: begin
          if (sq_done) begin
            cmp_q <= '0;
          end
        end
        S_ZERO: begin
          cmp_q <= cmp_q + 2'd1;
          if (last_cmp) begin
            pl_q <= pl_q + 3'd1;
          end
        end
        S_DIV_WAIT: begin
          if (dv_done) begin
            cmp_q <= cmp_q + 2'd1;
            if (last_cmp) begin
              pl_q <= pl_q + 3'd1;
            end
          end
        end
        S_TEST_D: begin
          if (pl_q != 3'(PLANE_CNT - 1)) begin
            pl_q  <= pl_q + 3'd1;
            cmp_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (action_i == ACT_TEST)) begin
      cx_q     <= center_x_i;
      cy_q     <= center_y_i;
      cz_q     <= center_z_i;
      radius_q <= sphere_radius_i;
      inside_q <= 1'b1;
    end
    case (state_q)
      S_CLIP_ACC: begin
        acc_q <= acc_new;
        if (k_q == 2'd3) begin
          if (col_q == 2'd3) begin
            clip_w_q[row_q] <= acc_new;
          end else begin
            clip_c_q[row_q][col_q] <= acc_new;
          end
        end
      end
      S_TEST_ACC: acc_q <= acc_new;
      S_LEN_ACC:  len2_q <= ((cmp_q == 2'd0) ? 64'd0 : len2_q) + prod;
      S_SQRT_WAIT: begin
        if (sq_done) begin
          root_q <= sq_root;
        end
      end
      S_TEST_D: begin
        if ((pl_q != 3'(PLANE_CNT - 1)) || !out_busy) begin
          inside_q <= inside_q && d_pass;
        end
        if ((pl_q == 3'(PLANE_CNT - 1)) && !out_busy) begin
          res_q <= inside_q && d_pass;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = res_q;

  // sequencing checks
  a_sqrt_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_SQRT_WAIT)) else $error("sqrt finished outside its wait");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> (state_q == S_DIV_WAIT)) else $error("divide finished outside its wait");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_TEST_D) && (pl_q == 3'(PLANE_CNT - 1)) && out_busy)
      |=> (state_q == S_TEST_D)) else $error("test finished over a pending result");

  a_build_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i == ACT_BUILD)) |=> (state_q == S_CLIP_MUL))
    else $error("build transaction did not start the clip pass");

endmodule

// ----- sv/fsc_mul.sv -----
// fsc_mul: shared 32x32 signed multiplier with registered operands and product
// depends on fsc_pkg for the saturation helper
module fsc_mul #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o,
  output logic signed [31:0] fixed_o
);
  import fsc_pkg::*;

  logic signed [31:0] a_q, b_q;
  logic signed [63:0] prod_q;

  // operand capture, then one multiply stage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    prod_q <= a_q * b_q;
  end

  // arithmetic shift rounds toward minus infinity
  assign prod_o  = prod_q;
  assign fixed_o = sat32(prod_q >>> FRAC_BITS);

endmodule

// ----- sv/fsc_sqrt.sv -----
// fsc_sqrt: iterative integer square root, two radicand bits per cycle
// uses nothing from fsc_pkg (no shared items needed)
module fsc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] n_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] rem_sh, trial;
  logic        ge;

  // one digit of the root per step
  assign rem_sh = {rem_q, n_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- sv/fsc_div.sv -----
// fsc_div: restoring divider for (x * 2^FRAC_BITS) / len, one quotient bit per cycle
// depends on fsc_pkg for the saturation helper
module fsc_div #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  import fsc_pkg::*;

  localparam int NW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NW);

  logic [NW-1:0]    dvd_q;
  logic [31:0]      rem_q, den_q;
  logic             neg_q, busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [32:0]      rem_sh, diff;
  logic             ge;
  logic [32:0]      mag;
  logic signed [63:0] ext, sval;

  assign mag    = num_i[31] ? 33'(-{num_i[31], num_i}) : {1'b0, num_i};
  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = (rem_sh >= {1'b0, den_q});

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(NW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // dividend shifts out while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag[31:0], {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[31];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], ge};
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
    end
  end

  // sign and saturate the magnitude quotient
  assign ext    = $signed({{(64-NW){1'b0}}, dvd_q});
  assign sval   = neg_q ? -ext : ext;
  assign quo_o  = sat32(sval);
  assign done_o = done_q;

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for frustum_sphere_culler (loads, plane builds, sphere tests)
// depends on fsc_pkg for the action codes and on the frustum_sphere_culler top level
module testbench;
  import fsc_pkg::*;

  localparam int FB = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_LOAD_VIEW;
  logic [3:0] matrix_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
  logic [30:0] sphere_radius = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic inside_res;

  typedef struct packed {
    action_e act;
    logic [3:0] idx;
    logic signed [31:0] val;
    logic signed [31:0] cx, cy, cz;
    logic [30:0] rad;
  } cull_item_t;

  cull_item_t pending_q[$];
  logic expected_inside_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  int hold_cycles = 0;

  // predictor state
  logic signed [31:0] view_m[16], proj_m[16], planes[24];

  always #1 clk_i = ~clk_i;

  frustum_sphere_culler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .matrix_index_i(matrix_index), .element_value_i(element_value),
    .center_x_i(center_x), .center_y_i(center_y), .center_z_i(center_z),
    .sphere_radius_i(sphere_radius), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .inside_res_o(inside_res)
  );

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
    return clamp32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
    return clamp32(66'(a) - 66'(b));
  endfunction

  // product floored by arithmetic shift
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return clamp32(p >>> FB);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // clip matrix, plane extraction and normalization
  task automatic build_frustum();
    logic signed [31:0] clip[16];
    logic signed [31:0] acc, w, c;
    logic [63:0] len2, len;
    logic signed [65:0] num, quo;
    int col;
    bit add;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = fx_mul(view_m[4*i], proj_m[j]);
        for (int k = 1; k < 4; k++) acc = fx_add(acc, fx_mul(view_m[4*i+k], proj_m[4*k+j]));
        clip[4*i+j] = acc;
      end
    for (int p = 0; p < 6; p++) begin
      col = p >> 1;
      add = (p == 1 || p == 2 || p == 5);
      for (int r = 0; r < 4; r++) begin
        w = clip[4*r+3];
        c = clip[4*r+col];
        planes[4*p+r] = add ? fx_add(w, c) : fx_sub(w, c);
      end
      len2 = 0;
      for (int q = 0; q < 3; q++) len2 += 64'(66'(planes[4*p+q]) * 66'(planes[4*p+q]));
      len = int_sqrt(len2);
      for (int q = 0; q < 4; q++) begin
        if (len == 0) begin
          planes[4*p+q] = '0;
        end else begin
          num = 66'(planes[4*p+q]) <<< FB;
          quo = num / $signed({2'b0, len});
          planes[4*p+q] = clamp32(quo);
        end
      end
    end
  endtask

  function automatic logic sphere_visible(input cull_item_t it);
    logic signed [31:0] d;
    for (int p = 0; p < 6; p++) begin
      d = fx_mul(planes[4*p], it.cx);
      d = fx_add(d, fx_mul(planes[4*p+1], it.cy));
      d = fx_add(d, fx_mul(planes[4*p+2], it.cz));
      d = fx_add(d, planes[4*p+3]);
      if (64'(d) <= -$signed({33'b0, it.rad})) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict(input cull_item_t it);
    case (it.act)
      ACT_LOAD_VIEW: view_m[it.idx] = it.val;
      ACT_LOAD_PROJ: proj_m[it.idx] = it.val;
      ACT_BUILD: build_frustum();
      default: expected_inside_q.push_back(sphere_visible(it));
    endcase
  endtask

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      3: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic cull_item_t mk(input action_e a, input logic [3:0] i,
                                    input logic signed [31:0] v);
    cull_item_t it;
    it.act = a; it.idx = i; it.val = v;
    it.cx = $urandom(); it.cy = $urandom(); it.cz = $urandom(); it.rad = 31'($urandom());
    return it;
  endfunction

  function automatic cull_item_t mk_test(input int mode);
    cull_item_t it;
    it = mk(ACT_TEST, 4'($urandom()), $urandom());
    if (mode == 0) begin
      it.cx = rnd_val(); it.cy = rnd_val(); it.cz = rnd_val();
      it.rad = $urandom_range(0, 1) ? 31'($urandom_range(0, 32'h0004_0000)) : 31'($urandom());
    end else begin
      it.cx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.cy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.cz = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.rad = 31'($urandom_range(0, 32'h0002_0000));
    end
    return it;
  endfunction

  // stimulus
  initial begin
    cull_item_t it;
    int n;
    for (int i = 0; i < 16; i++) begin
      view_m[i] = '0; proj_m[i] = '0;
    end
    for (int i = 0; i < 24; i++) planes[i] = '0;
    // directed: tests on reset planes, a zero-matrix build, an identity build with extreme corners
    it = mk_test(1); it.rad = '0; pending_q.push_back(it);
    it = mk_test(1); it.rad = 31'h7FFFFFFF; pending_q.push_back(it);
    pending_q.push_back(mk(ACT_BUILD, 4'd0, 32'sd0));
    it = mk_test(1); it.rad = '0; pending_q.push_back(it);
    for (int i = 0; i < 4; i++) begin
      pending_q.push_back(mk(ACT_LOAD_VIEW, 4'(5*i), 32'sh0001_0000));
      pending_q.push_back(mk(ACT_LOAD_PROJ, 4'(5*i), 32'sh0001_0000));
    end
    pending_q.push_back(mk(ACT_LOAD_VIEW, 4'd15, 32'sh7FFFFFFF));
    pending_q.push_back(mk(ACT_LOAD_PROJ, 4'd14, 32'sh80000000));
    pending_q.push_back(mk(ACT_BUILD, 4'd0, 32'sd0));
    it = mk_test(0); it.cx = 32'sh7FFFFFFF; it.cy = 32'sh80000000; pending_q.push_back(it);
    it = mk_test(0); it.cz = 32'sh80000000; it.rad = 31'h7FFFFFFF; pending_q.push_back(it);
    pending_q.push_back(mk_test(1));
    pending_q.push_back(mk_test(1));
    // random: matrix loads, a build in most rounds, then bursts of tests
    n = 0;
    while (n < 1800) begin
      for (int k = $urandom_range(0, 8); k > 0; k--) begin
        pending_q.push_back(mk($urandom_range(0, 1) ? ACT_LOAD_VIEW : ACT_LOAD_PROJ,
                               4'($urandom()), rnd_val()));
        n++;
      end
      if ($urandom_range(0, 3) != 0) begin
        pending_q.push_back(mk(ACT_BUILD, 4'($urandom()), $urandom()));
        n++;
      end
      for (int k = $urandom_range(5, 40); k > 0; k--) begin
        pending_q.push_back(mk_test($urandom_range(0, 2) == 0 ? 0 : 1));
        n++;
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stim_done = 1'b1;
  end

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni && stim_done) begin
      if (in_valid && !in_stall) predict(pending_q.pop_front());
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && !(in_valid && !in_stall && pending_q.size() == 0))
            begin
          in_valid <= 1'b1;
          action <= pending_q[0].act;
          matrix_index <= pending_q[0].idx;
          element_value <= pending_q[0].val;
          center_x <= pending_q[0].cx;
          center_y <= pending_q[0].cy;
          center_z <= pending_q[0].cz;
          sphere_radius <= pending_q[0].rad;
          in_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off early on
  int out_gap = 0;
  int out_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_cnt <= out_cnt + 1;
      if (out_cnt > 3000 && out_cnt < 4500) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles + 1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= (out_cnt % 4000 < 1500) ? 0 : gap_len();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_inside_q.size() == 0) begin
        report("result transaction with nothing expected");
      end else if (inside_res !== expected_inside_q[0]) begin
        report($sformatf("inside_res got %b want %b", inside_res, expected_inside_q[0]));
        void'(expected_inside_q.pop_front());
      end else begin
        void'(expected_inside_q.pop_front());
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pending_q.size() == 0 && !in_valid);
    wait (expected_inside_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && expected_inside_q.size() == 0) begin
      $display("[frustum_sphere_culler] OK");
    end else begin
      $display("[frustum_sphere_culler] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[frustum_sphere_culler] ERROR");
    $finish;
  end
endmodule
